>>> src/frustum_box_sphere_cull_unit_assert.svh
// Assertion macros for the frustum cull unit.
`ifndef FRUSTUM_BOX_SPHERE_CULL_UNIT_ASSERT_SVH
`define FRUSTUM_BOX_SPHERE_CULL_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define FBSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FBSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fbsc_pkg.sv
// ----------------------------------------------------------------------------
// fbsc_pkg
// Types and constants shared by the frustum cull unit.
// ----------------------------------------------------------------------------
package fbsc_pkg;

  localparam int unsigned VAL_BITS = 32;

  typedef enum logic [1:0] {
    MODE_LOAD_PLANE  = 2'd0,
    MODE_LOAD_CORNER = 2'd1,
    MODE_TEST_BOX    = 2'd2,
    MODE_TEST_SPHERE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2
  } state_t;

  typedef struct packed {
    mode_t                mode;
    logic [2:0]           slot;
    logic [VAL_BITS-1:0]  val_a;
    logic [VAL_BITS-1:0]  val_b;
    logic [VAL_BITS-1:0]  val_c;
    logic [VAL_BITS-1:0]  val_d;
    logic [VAL_BITS-1:0]  lo_x;
    logic [VAL_BITS-1:0]  lo_y;
    logic [VAL_BITS-1:0]  lo_z;
    logic [VAL_BITS-1:0]  hi_x;
    logic [VAL_BITS-1:0]  hi_y;
    logic [VAL_BITS-1:0]  hi_z;
  } in_item_t;

  typedef struct packed {
    logic visible;
    logic test_kind;
  } out_item_t;

  // Control from the sequencer to the evaluation datapath.
  typedef struct packed {
    logic       first;   // first step of a test: clear flags
    logic       valid;   // memory data of this step is present
    logic [2:0] idx;     // plane or corner index read a cycle ago
    logic       last;    // final step: result is complete after both eval stages
  } step_ctl_t;

endpackage

>>> src/frustum_box_sphere_cull_unit.sv
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull_unit
// Box and sphere culling against six stored planes and eight corners.
// ----------------------------------------------------------------------------
// A load item writes a plane or corner and gives no result. A test item walks
// the eight memory entries one per cycle through a registered read port and a
// two-stage product/sum datapath, then drains to a result in the output
// register; the next item is taken once that result register is free. Plane
// slots six and seven are read as the corner-only steps of the walk and never
// cull.
`include "frustum_box_sphere_cull_unit_assert.svh"

module frustum_box_sphere_cull_unit #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fbsc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fbsc_pkg::out_item_t  out_data
);

  fbsc_pkg::state_t state, state_next;
  logic [3:0]        cnt, cnt_next;
  fbsc_pkg::in_item_t item;
  logic               busy_out;

  logic plane_we, corner_we, accept;
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == fbsc_pkg::ST_IDLE) && !out_valid;
  assign plane_we  = accept && in_data.mode == fbsc_pkg::MODE_LOAD_PLANE;
  assign corner_we = accept && in_data.mode == fbsc_pkg::MODE_LOAD_CORNER;

  logic [4*WORD_BITS-1:0] plane_q;
  logic [3*WORD_BITS-1:0] corner_q;

  fbsc_store #(.WORD_BITS(WORD_BITS)) u_store (
    .clk(clk), .plane_we(plane_we), .corner_we(corner_we),
    .waddr(in_data.slot),
    .wa(in_data.val_a[WORD_BITS-1:0]), .wb(in_data.val_b[WORD_BITS-1:0]),
    .wc(in_data.val_c[WORD_BITS-1:0]), .wd(in_data.val_d[WORD_BITS-1:0]),
    .raddr(cnt[2:0]), .plane_q(plane_q), .corner_q(corner_q)
  );

  // Step k reads entry k; its data arrives with cnt = k+1.
  fbsc_pkg::step_ctl_t ctl;
  logic is_sphere, visible;
  assign is_sphere = item.mode == fbsc_pkg::MODE_TEST_SPHERE;

  always_comb begin
    ctl.valid = (state == fbsc_pkg::ST_RUN) && cnt != 4'd0;
    ctl.first = (state == fbsc_pkg::ST_RUN) && cnt == 4'd1;
    ctl.idx   = 3'(cnt - 4'd1);
    ctl.last  = (state == fbsc_pkg::ST_RUN) && cnt == 4'd8;
  end

  // Planes only exist at slots 0..5; sphere ignores corners.
  fbsc_pkg::step_ctl_t ctl_e;
  always_comb begin
    ctl_e = ctl;
    ctl_e.valid = ctl.valid;
  end

  logic [4*WORD_BITS-1:0] plane_m;
  logic [3*WORD_BITS-1:0] corner_m;
  logic plane_ok;
  // A plane with all-zero a,b,c and d = 0 gives sum 0: never culls.
  assign plane_ok = ctl.idx < 3'd6;
  assign plane_m  = plane_ok ? plane_q : '0;
  // For spheres use corners placed inside the bounds so they never cull.
  assign corner_m = is_sphere ? {item.val_a[WORD_BITS-1:0], item.val_b[WORD_BITS-1:0],
                                 item.val_c[WORD_BITS-1:0]} : corner_q;

  fbsc_eval #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_eval (
    .clk(clk), .ctl(ctl_e), .is_sphere(is_sphere),
    .lo_x(is_sphere ? item.val_a[WORD_BITS-1:0] : item.lo_x[WORD_BITS-1:0]),
    .lo_y(is_sphere ? item.val_b[WORD_BITS-1:0] : item.lo_y[WORD_BITS-1:0]),
    .lo_z(is_sphere ? item.val_c[WORD_BITS-1:0] : item.lo_z[WORD_BITS-1:0]),
    .hi_x(is_sphere ? item.val_a[WORD_BITS-1:0] : item.hi_x[WORD_BITS-1:0]),
    .hi_y(is_sphere ? item.val_b[WORD_BITS-1:0] : item.hi_y[WORD_BITS-1:0]),
    .hi_z(is_sphere ? item.val_c[WORD_BITS-1:0] : item.hi_z[WORD_BITS-1:0]),
    .rad(plane_ok ? item.val_d[WORD_BITS-1:0] : '0),
    .plane_q(plane_m), .corner_q(corner_m), .visible(visible)
  );

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    busy_out   = 1'b0;
    case (state)
      fbsc_pkg::ST_IDLE: begin
        if (accept && (in_data.mode == fbsc_pkg::MODE_TEST_BOX ||
                       in_data.mode == fbsc_pkg::MODE_TEST_SPHERE)) begin
          state_next = fbsc_pkg::ST_RUN;
          cnt_next   = 4'd0;
        end
      end
      fbsc_pkg::ST_RUN: begin
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd8) begin
          state_next = fbsc_pkg::ST_DRAIN;
          cnt_next   = 4'd0;
        end
      end
      fbsc_pkg::ST_DRAIN: begin
        // Two pipeline stages still settle the flags.
        cnt_next = cnt + 4'd1;
        busy_out = cnt == 4'd1;
        if (cnt == 4'd1) begin
          state_next = fbsc_pkg::ST_IDLE;
        end
      end
      default: state_next = fbsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbsc_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (busy_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (busy_out) begin
      out_data.visible   <= visible;
      out_data.test_kind <= is_sphere;
    end
  end

  `FBSC_ASSERT_IMPL(a_no_accept_busy, state != fbsc_pkg::ST_IDLE, !in_ready, "accept while busy")
  `FBSC_ASSERT_NEXT(a_result_valid, busy_out, out_valid, "result not posted")
  `FBSC_ASSERT_IMPL(a_cnt_range, state == fbsc_pkg::ST_RUN, cnt <= 4'd8, "step count overrun")

endmodule

>>> src/fbsc_store.sv
// ----------------------------------------------------------------------------
// fbsc_store
// Plane and corner memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbsc_store #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   plane_we,
  input  logic                   corner_we,
  input  logic [2:0]             waddr,
  input  logic [WORD_BITS-1:0]   wa,
  input  logic [WORD_BITS-1:0]   wb,
  input  logic [WORD_BITS-1:0]   wc,
  input  logic [WORD_BITS-1:0]   wd,
  input  logic [2:0]             raddr,
  output logic [4*WORD_BITS-1:0] plane_q,
  output logic [3*WORD_BITS-1:0] corner_q
);

  logic [4*WORD_BITS-1:0] plane_mem  [0:5];
  logic [3*WORD_BITS-1:0] corner_mem [0:7];

  always_ff @(posedge clk) begin
    if (plane_we && waddr < 3'd6) begin
      plane_mem[waddr] <= {wa, wb, wc, wd};
    end
    if (corner_we) begin
      corner_mem[waddr] <= {wa, wb, wc};
    end
    // Plane reads beyond the last slot return slot 0; only corners reach them.
    plane_q  <= plane_mem[(raddr < 3'd6) ? raddr : 3'd0];
    corner_q <= corner_mem[raddr];
  end

endmodule

>>> src/fbsc_eval.sv
// ----------------------------------------------------------------------------
// fbsc_eval
// One plane against the box corners and one frustum corner per step, with
// two registered stages: products, then sums and flag update.
// ----------------------------------------------------------------------------
module fbsc_eval #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk,
  input  fbsc_pkg::step_ctl_t    ctl,
  input  logic                   is_sphere,
  input  logic [WORD_BITS-1:0]   lo_x, lo_y, lo_z,
  input  logic [WORD_BITS-1:0]   hi_x, hi_y, hi_z,
  input  logic [WORD_BITS-1:0]   rad,
  input  logic [4*WORD_BITS-1:0] plane_q,
  input  logic [3*WORD_BITS-1:0] corner_q,
  output logic                   visible
);

  localparam int unsigned PB = 2 * WORD_BITS;
  localparam int unsigned SB = PB + 4;

  logic signed [WORD_BITS-1:0] pa, pb, pc, pd;
  logic signed [WORD_BITS-1:0] lx, ly, lz, hx, hy, hz;
  logic signed [WORD_BITS-1:0] cx, cy, cz;

  assign pa = plane_q[4*WORD_BITS-1:3*WORD_BITS];
  assign pb = plane_q[3*WORD_BITS-1:2*WORD_BITS];
  assign pc = plane_q[2*WORD_BITS-1:WORD_BITS];
  assign pd = plane_q[WORD_BITS-1:0];
  assign cx = corner_q[3*WORD_BITS-1:2*WORD_BITS];
  assign cy = corner_q[2*WORD_BITS-1:WORD_BITS];
  assign cz = corner_q[WORD_BITS-1:0];
  assign lx = lo_x; assign ly = lo_y; assign lz = lo_z;
  assign hx = hi_x; assign hy = hi_y; assign hz = hi_z;

  // Stage 1: six products (lo/hi on each axis) and the constant terms.
  logic signed [PB-1:0] m_ax0, m_ax1, m_by0, m_by1, m_cz0, m_cz1;
  logic signed [PB-1:0] m_d, m_r;
  logic                 s1_valid, s1_last, s1_first;
  logic [2:0]           cab, cbe;   // corner above / below per axis

  always_ff @(posedge clk) begin
    m_ax0 <= PB'(pa * lx);
    m_ax1 <= PB'(pa * (is_sphere ? lx : hx));
    m_by0 <= PB'(pb * ly);
    m_by1 <= PB'(pb * hy);
    m_cz0 <= PB'(pc * lz);
    m_cz1 <= PB'(pc * hz);
    m_d   <= PB'(PB'(pd) <<< FRAC_BITS);
    m_r   <= is_sphere ? PB'(PB'(signed'(rad)) <<< FRAC_BITS) : '0;
    cab   <= {cz > hz, cy > hy, cx > hx};
    cbe   <= {cz < lz, cy < ly, cx < lx};
    s1_valid <= ctl.valid;
    s1_last  <= ctl.last;
    s1_first <= ctl.first;
  end

  // Stage 2: eight corner sums; flags accumulate over steps.
  logic signed [SB-1:0] base, dot [0:7];
  logic                 all_neg;
  logic                 cull, cull_next;
  logic [2:0]           above, below, above_next, below_next;

  always_comb begin
    base = SB'(m_d) + SB'(m_r);
    all_neg = 1'b1;
    for (int k = 0; k < 8; k++) begin
      dot[k] = base + SB'(k[0] ? m_ax1 : m_ax0) + SB'(k[1] ? m_by1 : m_by0)
             + SB'(k[2] ? m_cz1 : m_cz0);
      if (!dot[k][SB-1]) begin
        all_neg = 1'b0;
      end
    end
    cull_next  = s1_first ? 1'b0 : cull;
    above_next = s1_first ? 3'b111 : above;
    below_next = s1_first ? 3'b111 : below;
    if (s1_valid) begin
      if (all_neg) begin
        cull_next = 1'b1;
      end
      above_next = above_next & cab;
      below_next = below_next & cbe;
    end
  end

  always_ff @(posedge clk) begin
    cull  <= cull_next;
    above <= above_next;
    below <= below_next;
  end

  // Sphere sums use lo = centre, so all eight sums are equal.
  assign visible = !(cull || (!is_sphere && ((|above) || (|below))));

  logic unused_last;
  assign unused_last = s1_last;

endmodule
